/* rtl/crg_pkg.sv */
package crg_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int X_W        = $clog2(MAX_WIDTH);
    localparam int Y_W        = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = X_W + Y_W;
    localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
    localparam int NX_W       = X_W + 2;
    localparam int NY_W       = Y_W + 2;

    localparam int DIM_W      = 7;
    localparam int PIX_W      = 8;
    localparam int CNT_W      = 13;
    localparam int SUM_W      = 20;
    localparam int LIM_W      = 16;
    localparam int NB_W       = 3;
    localparam int PROD_W     = SUM_W + CNT_W;
    localparam int BND_W      = LIM_W + CNT_W;
    localparam int RHS_W      = BND_W + CNT_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EIGHT_NB     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PERI_LIMIT   = 3'd5;

    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 7'd64;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 7'd64;
    localparam logic [LIM_W-1:0] RST_LIMIT        = 16'hFFFF;

    localparam logic signed [1:0] STEP_DX [8] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1,
                                                  -2'sd1, 2'sd1, 2'sd1, -2'sd1};
    localparam logic signed [1:0] STEP_DY [8] = '{-2'sd1, 2'sd0, 2'sd1, 2'sd0,
                                                  -2'sd1, -2'sd1, 2'sd1, 2'sd1};

    typedef enum logic [1:0] {
        MODE_WRITE,
        MODE_GROW,
        MODE_QUERY,
        MODE_NONE
    } t_mode;

    typedef enum logic [1:0] {
        REASON_AVG,
        REASON_PERI,
        REASON_COUNT,
        REASON_NONE
    } t_reason;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUERY,
        ST_SEED,
        ST_SEED_LOAD,
        ST_ROUND,
        ST_CTR_RD,
        ST_CTR_LAT,
        ST_NB_RD,
        ST_NB_LAT,
        ST_ACC,
        ST_CHK0,
        ST_CHK1,
        ST_CHK2,
        ST_DECIDE,
        ST_ADD
    } t_state;

    typedef enum logic [1:0] {
        RD_IN,
        RD_SEED,
        RD_CENTER,
        RD_NB
    } t_rd_src;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_QUERY,
        RES_GROW
    } t_res_sel;

    typedef struct packed {
        logic     in_take;
        logic     img_we;
        t_rd_src  rd_src;
        logic     clr_step;
        logic     seed_mark;
        logic     seed_init;
        logic     round_init;
        logic     center_lat;
        logic     nb_rd;
        logic     nb_lat;
        logic     acc;
        logic     add;
        logic     res_load;
        t_res_sel res_sel;
        t_reason  reason;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic seed_out;
        logic nb_last;
        logic scan_last;
        logic empty;
        logic stop_avg;
        logic stop_peri;
        logic at_limit;
        logic no_best;
    } t_sts;

endpackage

/* rtl/crg_in_if.sv */
interface crg_in_if import crg_pkg::*; ();
    logic             valid;
    logic             ready;
    t_mode            mode;
    logic [X_W-1:0]   col;
    logic [Y_W-1:0]   row;
    logic [PIX_W-1:0] pixel_value;

    modport source (output valid, output mode, output col, output row,
                    output pixel_value, input ready);
    modport sink   (input valid, input mode, input col, input row,
                    input pixel_value, output ready);
endinterface

/* rtl/crg_out_if.sv */
interface crg_out_if import crg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] region_count;
    t_reason          stop_reason;
    logic             in_region;

    modport source (output valid, output region_count, output stop_reason,
                    output in_region, input ready);
    modport sink   (input valid, input region_count, input stop_reason,
                    input in_region, output ready);
endinterface

/* rtl/crg_datapath.sv */
module crg_datapath import crg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [X_W-1:0]        i_col,
    input  logic [Y_W-1:0]        i_row,
    input  logic [PIX_W-1:0]      i_pixel_value,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic [CNT_W-1:0]      o_region_count,
    output t_reason               o_stop_reason,
    output logic                  o_in_region
);

    logic [DIM_W-1:0] r_cfg_width, r_cfg_height;
    logic             r_cfg_eight;
    logic [CNT_W-1:0] r_cfg_count;
    logic [LIM_W-1:0] r_cfg_alim, r_cfg_plim;

    logic [PIX_W-1:0] img_mem [CELLS];
    logic             mark_mem [CELLS];
    logic [PIX_W-1:0] r_pix_rd;
    logic             r_mark_rd;

    logic [ADDR_W-1:0] r_clr;
    logic [X_W-1:0]    r_sx, r_x, r_x0, r_x1, r_lx, r_bx;
    logic [Y_W-1:0]    r_sy, r_y, r_y0, r_y1, r_ly, r_by;
    logic              r_q_ok;
    logic [SUM_W-1:0]  r_sum, r_ib, r_cb;
    logic [CNT_W-1:0]  r_count, r_p1, r_p2;
    logic [PIX_W-1:0]  r_best, r_v;
    logic              r_cm, r_has_m, r_has_u, r_nb_ok;
    logic [NB_W-1:0]   r_k;

    logic [PROD_W-1:0] r_m1, r_m2, r_m3, r_m4, r_da, r_dp;
    logic [BND_W-1:0]  r_m5, r_m6;
    logic [RHS_W-1:0]  r_ra, r_rp;
    logic              r_stop_a, r_stop_p;

    logic [CNT_W-1:0]  r_res_count;
    t_reason           r_res_reason;
    logic              r_res_hit;

    logic [DIM_W-1:0]        w, h, lx1, ly1;
    logic signed [NX_W-1:0]  nx;
    logic signed [NY_W-1:0]  ny;
    logic                    nb_ok, seed_out, q_ok;
    logic [ADDR_W-1:0]       rd_addr, mark_waddr;
    logic                    mark_we;
    logic [X_W-1:0]          nx0, nx1;
    logic [Y_W-1:0]          ny0, ny1;

    // size in use: zero acts as one, large values saturate
    always_comb begin
        if (r_cfg_width == '0) begin
            w = DIM_W'(1);
        end else if (r_cfg_width > DIM_W'(MAX_WIDTH)) begin
            w = DIM_W'(MAX_WIDTH);
        end else begin
            w = r_cfg_width;
        end
        if (r_cfg_height == '0) begin
            h = DIM_W'(1);
        end else if (r_cfg_height > DIM_W'(MAX_HEIGHT)) begin
            h = DIM_W'(MAX_HEIGHT);
        end else begin
            h = r_cfg_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_IMAGE_WIDTH;
            r_cfg_height <= RST_IMAGE_HEIGHT;
            r_cfg_eight  <= 1'b0;
            r_cfg_count  <= '0;
            r_cfg_alim   <= RST_LIMIT;
            r_cfg_plim   <= RST_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data[DIM_W-1:0];
                CFG_EIGHT_NB:     r_cfg_eight  <= i_cfg_data[0];
                CFG_COUNT_LIMIT:  r_cfg_count  <= i_cfg_data[CNT_W-1:0];
                CFG_AVG_LIMIT:    r_cfg_alim   <= i_cfg_data[LIM_W-1:0];
                CFG_PERI_LIMIT:   r_cfg_plim   <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // neighbor k of the current pixel
    assign nx    = $signed({2'b00, r_x}) + NX_W'(STEP_DX[r_k]);
    assign ny    = $signed({2'b00, r_y}) + NY_W'(STEP_DY[r_k]);
    assign nb_ok = (nx >= 0) && (nx < $signed(NX_W'(w)))
                && (ny >= 0) && (ny < $signed(NY_W'(h)));

    assign seed_out = (DIM_W'(r_sx) >= w) || (DIM_W'(r_sy) >= h);
    assign q_ok     = (DIM_W'(i_col) < w) && (DIM_W'(i_row) < h);

    always_comb begin
        case (i_cmd.rd_src)
            RD_IN:     rd_addr = {i_row, i_col};
            RD_SEED:   rd_addr = {r_sy, r_sx};
            RD_CENTER: rd_addr = {r_y, r_x};
            RD_NB:     rd_addr = {ny[Y_W-1:0], nx[X_W-1:0]};
            default:   rd_addr = {r_y, r_x};
        endcase
    end

    assign mark_we    = i_cmd.clr_step | i_cmd.seed_mark | i_cmd.add;
    assign mark_waddr = i_cmd.clr_step  ? r_clr :
                        i_cmd.seed_mark ? {r_sy, r_sx} : {r_by, r_bx};

    always_ff @(posedge i_clk) begin
        if (i_cmd.img_we) begin
            img_mem[{i_row, i_col}] <= i_pixel_value;
        end
        r_pix_rd <= img_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            mark_mem[mark_waddr] <= !i_cmd.clr_step;
        end
        r_mark_rd <= mark_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // bounding box widened around the pixel added last
    assign lx1 = DIM_W'(r_lx) + 1'b1;
    assign ly1 = DIM_W'(r_ly) + 1'b1;
    assign nx0 = (r_lx != '0 && (r_lx - 1'b1) < r_x0) ? r_lx - 1'b1 : r_x0;
    assign ny0 = (r_ly != '0 && (r_ly - 1'b1) < r_y0) ? r_ly - 1'b1 : r_y0;
    assign nx1 = (lx1 < w && lx1 > DIM_W'(r_x1)) ? X_W'(lx1) : r_x1;
    assign ny1 = (ly1 < h && ly1 > DIM_W'(r_y1)) ? Y_W'(ly1) : r_y1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_take) begin
            r_sx   <= i_col;
            r_sy   <= i_row;
            r_q_ok <= q_ok;
        end
        if (i_cmd.seed_init) begin
            r_sum   <= SUM_W'(r_pix_rd);
            r_count <= CNT_W'(1);
            r_x0    <= r_sx;
            r_x1    <= r_sx;
            r_y0    <= r_sy;
            r_y1    <= r_sy;
            r_lx    <= r_sx;
            r_ly    <= r_sy;
        end
        if (i_cmd.round_init) begin
            r_x0   <= nx0;
            r_x1   <= nx1;
            r_y0   <= ny0;
            r_y1   <= ny1;
            r_x    <= nx0;
            r_y    <= ny0;
            r_ib   <= '0;
            r_cb   <= '0;
            r_p1   <= '0;
            r_p2   <= '0;
            r_best <= '0;
        end
        if (i_cmd.center_lat) begin
            r_v     <= r_pix_rd;
            r_cm    <= r_mark_rd;
            r_has_m <= 1'b0;
            r_has_u <= 1'b0;
            r_k     <= '0;
        end
        if (i_cmd.nb_rd) begin
            r_nb_ok <= nb_ok;
        end
        if (i_cmd.nb_lat) begin
            if (r_nb_ok) begin
                if (r_mark_rd) begin
                    r_has_m <= 1'b1;
                end else begin
                    r_has_u <= 1'b1;
                end
            end
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.acc) begin
            if (r_cm) begin
                if (r_has_u) begin
                    r_ib <= r_ib + SUM_W'(r_v);
                    r_p1 <= r_p1 + 1'b1;
                end
            end else if (r_has_m) begin
                r_cb <= r_cb + SUM_W'(r_v);
                r_p2 <= r_p2 + 1'b1;
                // strict compare keeps the first in raster order
                if (r_v > r_best) begin
                    r_best <= r_v;
                    r_bx   <= r_x;
                    r_by   <= r_y;
                end
            end
            if (r_x == r_x1) begin
                r_x <= r_x0;
                r_y <= r_y + 1'b1;
            end else begin
                r_x <= r_x + 1'b1;
            end
        end
        if (i_cmd.add) begin
            r_sum   <= r_sum + SUM_W'(r_best);
            r_count <= r_count + 1'b1;
            r_lx    <= r_bx;
            r_ly    <= r_by;
        end
    end

    // contrast tests by cross-multiplication, three register stages
    always_ff @(posedge i_clk) begin
        r_m1 <= PROD_W'(r_sum) * PROD_W'(r_p2);
        r_m2 <= PROD_W'(r_cb) * PROD_W'(r_count);
        r_m3 <= PROD_W'(r_ib) * PROD_W'(r_p2);
        r_m4 <= PROD_W'(r_cb) * PROD_W'(r_p1);
        r_m5 <= BND_W'(r_cfg_alim) * BND_W'(r_count);
        r_m6 <= BND_W'(r_cfg_plim) * BND_W'(r_p1);

        r_da <= (r_m1 > r_m2) ? r_m1 - r_m2 : r_m2 - r_m1;
        r_dp <= (r_m3 > r_m4) ? r_m3 - r_m4 : r_m4 - r_m3;
        r_ra <= RHS_W'(r_m5) * RHS_W'(r_p2);
        r_rp <= RHS_W'(r_m6) * RHS_W'(r_p2);

        r_stop_a <= RHS_W'({r_da, 8'h00}) > r_ra;
        r_stop_p <= RHS_W'({r_dp, 8'h00}) > r_rp;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            case (i_cmd.res_sel)
                RES_QUERY: begin
                    r_res_count  <= '0;
                    r_res_reason <= REASON_AVG;
                    r_res_hit    <= r_q_ok & r_mark_rd;
                end
                RES_GROW: begin
                    r_res_count  <= seed_out ? '0 : r_count;
                    r_res_reason <= i_cmd.reason;
                    r_res_hit    <= 1'b0;
                end
                default: begin
                    r_res_count  <= '0;
                    r_res_reason <= REASON_AVG;
                    r_res_hit    <= 1'b0;
                end
            endcase
        end
    end

    assign o_region_count = r_res_count;
    assign o_stop_reason  = r_res_reason;
    assign o_in_region    = r_res_hit;

    always_comb begin
        o_sts.clr_last  = (r_clr == ADDR_W'(CELLS - 1));
        o_sts.seed_out  = seed_out;
        o_sts.nb_last   = (r_k == (r_cfg_eight ? NB_W'(7) : NB_W'(3)));
        o_sts.scan_last = (r_x == r_x1) && (r_y == r_y1);
        o_sts.empty     = (r_p1 == '0) || (r_p2 == '0);
        o_sts.stop_avg  = r_stop_a;
        o_sts.stop_peri = r_stop_p;
        o_sts.at_limit  = (r_cfg_count != '0) && (r_count >= r_cfg_count);
        o_sts.no_best   = (r_best == '0);
    end

endmodule

/* rtl/crg_ctrl.sv */
module crg_ctrl import crg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_mode i_mode,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_sts  i_sts,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_grow_pend, n_grow_pend;
    logic   r_out_valid, n_out_valid;
    logic   accept, stop;

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign stop        = i_sts.empty || i_sts.stop_avg || i_sts.stop_peri
                      || i_sts.at_limit || i_sts.no_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_grow_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_grow_pend <= n_grow_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_grow_pend = r_grow_pend;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state     = r_grow_pend ? ST_SEED : ST_IDLE;
                    n_grow_pend = 1'b0;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_mode == MODE_GROW) begin
                        n_state     = ST_CLEAR;
                        n_grow_pend = 1'b1;
                    end else if (i_mode == MODE_QUERY) begin
                        n_state = ST_QUERY;
                    end
                end
            end
            ST_QUERY:     n_state = ST_IDLE;
            ST_SEED:      n_state = i_sts.seed_out ? ST_IDLE : ST_SEED_LOAD;
            ST_SEED_LOAD: n_state = ST_ROUND;
            ST_ROUND:     n_state = ST_CTR_RD;
            ST_CTR_RD:    n_state = ST_CTR_LAT;
            ST_CTR_LAT:   n_state = ST_NB_RD;
            ST_NB_RD:     n_state = ST_NB_LAT;
            ST_NB_LAT:    n_state = i_sts.nb_last ? ST_ACC : ST_NB_RD;
            ST_ACC:       n_state = i_sts.scan_last ? ST_CHK0 : ST_CTR_RD;
            ST_CHK0:      n_state = ST_CHK1;
            ST_CHK1:      n_state = ST_CHK2;
            ST_CHK2:      n_state = ST_DECIDE;
            ST_DECIDE:    n_state = stop ? ST_IDLE : ST_ADD;
            ST_ADD:       n_state = ST_ROUND;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.rd_src  = RD_CENTER;
        o_cmd.res_sel = RES_ZERO;
        o_cmd.reason  = REASON_AVG;
        case (r_state)
            ST_CLEAR: o_cmd.clr_step = 1'b1;
            ST_IDLE: begin
                o_cmd.rd_src  = RD_IN;
                o_cmd.in_take = accept;
                if (accept) begin
                    case (i_mode)
                        MODE_WRITE: begin
                            o_cmd.img_we   = 1'b1;
                            o_cmd.res_load = 1'b1;
                        end
                        MODE_NONE: o_cmd.res_load = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_QUERY: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_sel  = RES_QUERY;
            end
            ST_SEED: begin
                o_cmd.rd_src = RD_SEED;
                if (i_sts.seed_out) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_GROW;
                    o_cmd.reason   = REASON_NONE;
                end else begin
                    o_cmd.seed_mark = 1'b1;
                end
            end
            ST_SEED_LOAD: o_cmd.seed_init  = 1'b1;
            ST_ROUND:     o_cmd.round_init = 1'b1;
            ST_CTR_RD:    o_cmd.rd_src     = RD_CENTER;
            ST_CTR_LAT:   o_cmd.center_lat = 1'b1;
            ST_NB_RD: begin
                o_cmd.rd_src = RD_NB;
                o_cmd.nb_rd  = 1'b1;
            end
            ST_NB_LAT:    o_cmd.nb_lat = 1'b1;
            ST_ACC:       o_cmd.acc    = 1'b1;
            ST_DECIDE: begin
                if (stop) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_GROW;
                    if (i_sts.empty) begin
                        o_cmd.reason = REASON_NONE;
                    end else if (i_sts.stop_avg) begin
                        o_cmd.reason = REASON_AVG;
                    end else if (i_sts.stop_peri) begin
                        o_cmd.reason = REASON_PERI;
                    end else if (i_sts.at_limit) begin
                        o_cmd.reason = REASON_COUNT;
                    end else begin
                        o_cmd.reason = REASON_NONE;
                    end
                end
            end
            ST_ADD:       o_cmd.add = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        if (o_cmd.res_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

/* rtl/contrast_region_grow.sv */
// Contrast-limited region growing on a 64x64 8-bit image held on chip.
// Mode 0 writes a pixel and mode 3 does nothing; both can follow each
// other every cycle while each result is taken. Mode 2 reads a region
// mark (one mark-memory read). Mode 1 clears the 4096 marks, one per
// cycle, marks and loads the seed, then grows: each round has a setup
// step, walks the bounding box plus one pixel, reading the center and
// N = 4 or 8 neighbors per box pixel (each a separate mark-memory read),
// runs the contrast arithmetic through its registers, then decides and
// adds a pixel unless it stops. After reset the block clears all 4096
// marks before it accepts the first transaction; configuration writes
// are for the idle block only, which is the user's duty: the block itself
// does not enforce it. Every accepted transaction returns exactly one
// result transaction; a finished result waits in an output register until taken.
module contrast_region_grow import crg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    crg_in_if.sink                i_in_ch,
    crg_out_if.source             o_out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    crg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .i_mode      (i_in_ch.mode),
        .o_in_ready  (i_in_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .i_out_ready (o_out_ch.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    crg_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_col          (i_in_ch.col),
        .i_row          (i_in_ch.row),
        .i_pixel_value  (i_in_ch.pixel_value),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_region_count (o_out_ch.region_count),
        .o_stop_reason  (o_out_ch.stop_reason),
        .o_in_region    (o_out_ch.in_region)
    );

endmodule
